FILE: design/nrw_pkg.sv
// shared types and constants of the name registry with waiters
package nrw_pkg;

  localparam int NUM_TASKS_DEF  = 32;
  localparam int NAME_BYTES_DEF = 8;
  localparam int TASK_FW        = 5;
  localparam int NAME_FW        = 64;
  localparam int STATUS_FW      = 2;

  localparam logic FUNC_REG  = 1'b0;
  localparam logic FUNC_LOOK = 1'b1;

  localparam logic [STATUS_FW-1:0] ST_ACK    = 2'd0;
  localparam logic [STATUS_FW-1:0] ST_ANSWER = 2'd1;
  localparam logic [STATUS_FW-1:0] ST_BAD    = 2'd2;

  // request token walking down the cell row
  typedef struct packed {
    logic               valid;
    logic               func;
    logic [TASK_FW-1:0] req;
    logic               hit;
    logic [TASK_FW-1:0] slot;
  } tok_t;

  typedef struct packed {
    logic [TASK_FW-1:0]   reply_task;
    logic [STATUS_FW-1:0] status;
    logic [TASK_FW-1:0]   found_task;
  } res_t;

  typedef struct packed {
    logic valid;
    res_t res;
  } emit_t;

endpackage

FILE: design/name_registry_with_waiters_top.sv
// name registry top level: request intake, cell row, result hold and output register
//
// Requests enter on the in_ stream: in_tuser is the function (0 register,
// 1 look up), in_tdata carries requester and name. One request is taken at a
// time; in_tready stays low while it is worked on.
// A request token walks the row of NUM_TASKS cells, one cell per cycle when
// the row is not stalled. Empty names and out-of-range requesters are answered
// without touching the row.
// Results leave on the out_ stream: out_tuser is the status, out_tdata the
// reply and found task, out_tlast marks the final result of a request.
// A register request yields its ack and then one answer per released waiter
// in ascending slot order; a lookup yields one answer or none when parked.
// One result is held back so that tlast can be set on the final one; when
// a new result meets a stalled output, the token stops in the row until it frees.
// Synchronous active-low reset clears all names, pending lookups and valids.
module name_registry_with_waiters_top #(
  parameter int NUM_TASKS  = nrw_pkg::NUM_TASKS_DEF,
  parameter int NAME_BYTES = nrw_pkg::NAME_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // requester[4:0], name[68:5], zero fill
  input  logic        in_tuser,   // func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // reply_task[4:0], found_task[9:5], zero fill
  output logic [1:0]  out_tuser,  // status
  output logic        out_tlast
);

  localparam int NAME_W = 8 * NAME_BYTES;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_FLUSH = 2'd2;

  logic [1:0]                  state_r, state_nxt;
  logic [NAME_W-1:0]           name_r, name_nxt;
  nrw_pkg::tok_t               inj_r, inj_nxt;
  logic                        hold_valid_r, hold_valid_nxt;
  nrw_pkg::res_t               hold_r, hold_nxt;
  logic                        out_valid_r, out_valid_nxt;
  nrw_pkg::res_t               out_r, out_nxt;
  logic                        out_last_r, out_last_nxt;

  logic [nrw_pkg::TASK_FW-1:0] in_req;
  logic [NAME_W-1:0]           in_name;
  logic                        in_bad, accept;
  nrw_pkg::tok_t               chain [NUM_TASKS];
  nrw_pkg::emit_t              emits [NUM_TASKS];
  nrw_pkg::tok_t               tail;
  logic                        tail_emit, emit_any, out_free, adv, park_en;
  nrw_pkg::res_t               new_res;

  assign in_req = in_tdata[nrw_pkg::TASK_FW-1:0];
  assign accept = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);

  // name ends at its first zero byte
  always_comb begin
    logic alive;
    alive = 1'b1;
    in_name = '0;
    for (int b = 0; b < NAME_BYTES; b++) begin
      if (in_tdata[nrw_pkg::TASK_FW + 8*b +: 8] == 8'd0) begin
        alive = 1'b0;
      end
      if (alive) begin
        in_name[8*b +: 8] = in_tdata[nrw_pkg::TASK_FW + 8*b +: 8];
      end
    end
  end

  assign in_bad = (in_name == '0) || (int'(in_req) >= NUM_TASKS);

  for (genvar i = 0; i < NUM_TASKS; i++) begin : g_cell
    nrw_cell #(
      .IDX    (i),
      .NAME_W (NAME_W)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .adv      (adv),
      .tok_i    ((i == 0) ? inj_r : chain[(i == 0) ? 0 : i - 1]),
      .tok_o    (chain[i]),
      .name_i   (name_r),
      .park_en  (park_en),
      .park_req (tail.req),
      .emit_o   (emits[i])
    );
  end

  assign tail = chain[NUM_TASKS-1];
  assign tail_emit = tail.valid && tail.func == nrw_pkg::FUNC_LOOK && tail.hit;
  assign park_en = adv && tail.valid && tail.func == nrw_pkg::FUNC_LOOK && !tail.hit;

  // only one token is in flight, so at most one source is active
  always_comb begin
    emit_any = tail_emit;
    new_res = '0;
    if (tail_emit) begin
      new_res.reply_task = tail.req;
      new_res.status = nrw_pkg::ST_ANSWER;
      new_res.found_task = tail.slot;
    end
    for (int i = 0; i < NUM_TASKS; i++) begin
      emit_any = emit_any | emits[i].valid;
      new_res = new_res | (emits[i].valid ? emits[i].res : '0);
    end
  end

  assign out_free = !out_valid_r || out_tready;
  assign adv = (state_r == S_SCAN) && !(emit_any && hold_valid_r && !out_free);

  always_comb begin
    state_nxt = state_r;
    name_nxt = name_r;
    inj_nxt = inj_r;
    hold_valid_nxt = hold_valid_r;
    hold_nxt = hold_r;
    out_valid_nxt = out_free ? 1'b0 : out_valid_r;
    out_nxt = out_r;
    out_last_nxt = out_last_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          hold_nxt.reply_task = in_req;
          hold_nxt.found_task = '0;
          if (in_bad) begin
            hold_nxt.status = nrw_pkg::ST_BAD;
            hold_valid_nxt = 1'b1;
            state_nxt = S_FLUSH;
          end else begin
            hold_nxt.status = nrw_pkg::ST_ACK;
            hold_valid_nxt = (in_tuser == nrw_pkg::FUNC_REG);
            name_nxt = in_name;
            inj_nxt = '0;
            inj_nxt.valid = 1'b1;
            inj_nxt.func = in_tuser;
            inj_nxt.req = in_req;
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (adv) begin
          inj_nxt.valid = 1'b0;
          if (emit_any) begin
            // older held result goes out, not final
            if (hold_valid_r) begin
              out_valid_nxt = 1'b1;
              out_nxt = hold_r;
              out_last_nxt = 1'b0;
            end
            hold_nxt = new_res;
            hold_valid_nxt = 1'b1;
          end
          if (tail.valid) begin
            state_nxt = S_FLUSH;
          end
        end
      end
      S_FLUSH: begin
        if (!hold_valid_r) begin
          state_nxt = S_IDLE;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          out_nxt = hold_r;
          out_last_nxt = 1'b1;
          hold_valid_nxt = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      inj_r <= '0;
      hold_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      inj_r <= inj_nxt;
      hold_valid_r <= hold_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    name_r <= name_nxt;
    hold_r <= hold_nxt;
    out_r <= out_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = {6'd0, out_r.found_task, out_r.reply_task};
  assign out_tuser = out_r.status;
  assign out_tlast = out_last_r;

endmodule

FILE: design/nrw_cell.sv
// one task slot: owned name, pending lookup name and a token stage
module nrw_cell #(
  parameter int IDX    = 0,
  parameter int NAME_W = 8 * nrw_pkg::NAME_BYTES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        adv,
  input  nrw_pkg::tok_t               tok_i,
  output nrw_pkg::tok_t               tok_o,
  input  logic [NAME_W-1:0]           name_i,
  input  logic                        park_en,
  input  logic [nrw_pkg::TASK_FW-1:0] park_req,
  output nrw_pkg::emit_t              emit_o
);

  localparam logic                        IDX_OK = (IDX < (1 << nrw_pkg::TASK_FW));
  localparam logic [nrw_pkg::TASK_FW-1:0] MY_ID  = nrw_pkg::TASK_FW'(IDX);

  logic [NAME_W-1:0] owner_r, owner_nxt;
  logic [NAME_W-1:0] pend_r, pend_nxt;
  nrw_pkg::tok_t     tok_r, tok_nxt;
  logic              own_hit, pend_hit, is_me, act;

  assign own_hit = (owner_r == name_i);
  assign pend_hit = (pend_r == name_i);
  assign is_me = IDX_OK && (tok_i.req == MY_ID);
  assign act = adv && tok_i.valid;

  always_comb begin
    owner_nxt = owner_r;
    pend_nxt = pend_r;
    tok_nxt = tok_i;
    emit_o = '0;
    if (tok_i.valid && tok_i.func == nrw_pkg::FUNC_REG) begin
      // set for the requester, drop the name from any other slot
      if (is_me) begin
        owner_nxt = name_i;
      end else if (own_hit) begin
        owner_nxt = '0;
      end
      if (pend_hit) begin
        pend_nxt = '0;
        emit_o.valid = 1'b1;
        emit_o.res.reply_task = MY_ID;
        emit_o.res.status = nrw_pkg::ST_ANSWER;
        emit_o.res.found_task = tok_i.req;
      end
    end else if (tok_i.valid && !tok_i.hit && own_hit) begin
      tok_nxt.hit = 1'b1;
      tok_nxt.slot = MY_ID;
    end
    if (park_en && IDX_OK && park_req == MY_ID) begin
      pend_nxt = name_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owner_r <= '0;
      pend_r <= '0;
      tok_r <= '0;
    end else begin
      if (act || park_en) begin
        owner_r <= act ? owner_nxt : owner_r;
        pend_r <= pend_nxt;
      end
      if (adv) begin
        tok_r <= tok_nxt;
      end
    end
  end

  assign tok_o = tok_r;

endmodule

FILE: design/nrw_checker.sv
// port-level checks of the name registry, bound to the top level
module nrw_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic [1:0]  out_tuser,
  input logic        out_tlast
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
      $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled result changed");

  // one request at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request taken while busy");

  // a bad request is always its own final result
  a_bad_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == nrw_pkg::ST_BAD |-> out_tlast)
    else $error("bad-request result without tlast");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser == nrw_pkg::ST_ACK || out_tuser == nrw_pkg::ST_ANSWER ||
      out_tuser == nrw_pkg::ST_BAD)
    else $error("unknown status code");

endmodule

bind name_registry_with_waiters_top nrw_checker u_nrw_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
